/* design/rau_pkg.sv */
// rau_pkg: types, operation and status codes of the rational arithmetic unit.
// Used by every module in the design folder; depends on nothing.
package rau_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned FLD_W  = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned MAG_W  = FLD_W + 1;   // magnitude of one field
  localparam int unsigned ACC_W  = 2 * MAG_W;   // cross-product and sum
  localparam int unsigned SHF_W  = 7;           // holds 0..ACC_W

  // Operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;
  localparam logic [2:0] OP_EQU = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [FLD_W-1:0] a_num;
    logic signed [FLD_W-1:0] a_den;
    logic signed [FLD_W-1:0] b_num;
    logic signed [FLD_W-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic [1:0]              status;
    logic                    is_equal;
  } out_t;

  // Classified work item passed from front to back
  typedef struct packed {
    logic             done;     // result known, no arithmetic needed
    logic [1:0]       status;
    logic             is_equal;
    logic [MAG_W-1:0] m0a;      // first numerator term operands
    logic [MAG_W-1:0] m0b;
    logic             neg0;
    logic [MAG_W-1:0] m1a;      // second numerator term operands
    logic [MAG_W-1:0] m1b;
    logic             neg1;
    logic [MAG_W-1:0] m2a;      // denominator operands
    logic [MAG_W-1:0] m2b;
    logic             negd;
  } work_t;

endpackage

/* design/rau_front.sv */
// rau_front: accepts requests, converts fields to sign-magnitude and sorts
// out special cases. Depends on rau_pkg.
module rau_front #(
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::in_t  in_data,
  output logic          push,
  input  logic          q_full,
  output rau_pkg::work_t push_item
);

  localparam logic [rau_pkg::MAG_W-1:0] FULL = rau_pkg::MAG_W'(1) << FIELD_WIDTH;
  localparam logic [rau_pkg::FLD_W-1:0] MASK = rau_pkg::FLD_W'(FULL - 1'b1);
  localparam logic [rau_pkg::MAG_W-1:0] ONE  = rau_pkg::MAG_W'(1);

  logic           f_valid_r, f_valid_nxt;
  rau_pkg::work_t f_item_r, f_item_nxt;
  logic           accept;

  logic [rau_pkg::MAG_W-1:0] an, ad, bn, bd;
  logic                      san, sad, sbn, sbd;

  // Take low field bits as two's complement, return magnitude
  function automatic logic [rau_pkg::MAG_W-1:0] mag_of(input logic [rau_pkg::FLD_W-1:0] f);
    logic [rau_pkg::FLD_W-1:0] v;
    v = f & MASK;
    mag_of = f[FIELD_WIDTH-1] ? (FULL - {1'b0, v}) : {1'b0, v};
  endfunction

  assign in_stall  = f_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_valid_r && !q_full;
  assign push_item = f_item_r;

  assign an  = mag_of(in_data.a_num);
  assign ad  = mag_of(in_data.a_den);
  assign bn  = mag_of(in_data.b_num);
  assign bd  = mag_of(in_data.b_den);
  assign san = in_data.a_num[FIELD_WIDTH-1];
  assign sad = in_data.a_den[FIELD_WIDTH-1];
  assign sbn = in_data.b_num[FIELD_WIDTH-1];
  assign sbd = in_data.b_den[FIELD_WIDTH-1];

  // Classify request and select multiplier operands
  always_comb begin
    f_item_nxt          = '0;
    f_item_nxt.status   = rau_pkg::ST_OK;
    if (in_data.operation == rau_pkg::OP_EQU) begin
      f_item_nxt.done     = 1'b1;
      f_item_nxt.is_equal = (((in_data.a_num ^ in_data.b_num) & MASK) == '0) &&
                            (((in_data.a_den ^ in_data.b_den) & MASK) == '0);
    end else if (in_data.operation > rau_pkg::OP_EQU) begin
      f_item_nxt.done = 1'b1;
    end else if (ad == '0 || (in_data.operation != rau_pkg::OP_RED && bd == '0)) begin
      f_item_nxt.done   = 1'b1;
      f_item_nxt.status = rau_pkg::ST_ZDEN;
    end else if (in_data.operation == rau_pkg::OP_DIV && bn == '0) begin
      f_item_nxt.done   = 1'b1;
      f_item_nxt.status = rau_pkg::ST_DIVZ;
    end else begin
      case (in_data.operation)
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          f_item_nxt.m0a  = an;
          f_item_nxt.m0b  = bd;
          f_item_nxt.neg0 = san ^ sbd;
          f_item_nxt.m1a  = bn;
          f_item_nxt.m1b  = ad;
          f_item_nxt.neg1 = sbn ^ sad ^ (in_data.operation == rau_pkg::OP_SUB);
          f_item_nxt.m2a  = ad;
          f_item_nxt.m2b  = bd;
          f_item_nxt.negd = sad ^ sbd;
        end
        rau_pkg::OP_MUL: begin
          f_item_nxt.m0a  = an;
          f_item_nxt.m0b  = bn;
          f_item_nxt.neg0 = san ^ sbn;
          f_item_nxt.m2a  = ad;
          f_item_nxt.m2b  = bd;
          f_item_nxt.negd = sad ^ sbd;
        end
        rau_pkg::OP_DIV: begin
          f_item_nxt.m0a  = an;
          f_item_nxt.m0b  = bd;
          f_item_nxt.neg0 = san ^ sbd;
          f_item_nxt.m2a  = ad;
          f_item_nxt.m2b  = bn;
          f_item_nxt.negd = sad ^ sbn;
        end
        default: begin
          f_item_nxt.m0a  = an;
          f_item_nxt.m0b  = ONE;
          f_item_nxt.neg0 = san;
          f_item_nxt.m2a  = ad;
          f_item_nxt.m2b  = ONE;
          f_item_nxt.negd = sad;
        end
      endcase
    end
  end

  // Hold the classified request until the queue takes it
  always_comb begin
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

/* design/rau_queue.sv */
// rau_queue: two-entry queue of work items between front and back.
// Depends on rau_pkg.
module rau_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rau_pkg::work_t push_item,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output rau_pkg::work_t pop_item
);

  rau_pkg::work_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop_item = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/rau_back.sv */
// rau_back: cross-products on one shared multiplier, binary gcd, two
// bit-serial divisions and range check. Depends on rau_pkg.
module rau_back #(
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  rau_pkg::work_t pop_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output rau_pkg::out_t  out_data
);

  localparam int unsigned AW = rau_pkg::ACC_W;
  localparam logic [AW-1:0] HALF = AW'(1) << (FIELD_WIDTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIVN = 3'd4;
  localparam logic [2:0] S_DIVD = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [rau_pkg::SHF_W-1:0] cnt_r, cnt_nxt;
  rau_pkg::work_t        item_r, item_nxt;
  logic [AW-1:0]         t0_r, t0_nxt, t1_r, t1_nxt, d_r, d_nxt;
  logic [AW-1:0]         num_r, num_nxt;
  logic                  nneg_r, nneg_nxt;
  logic [AW-1:0]         gx_r, gx_nxt, gy_r, gy_nxt;
  logic [AW-1:0]         g_r, g_nxt, dvd_r, dvd_nxt, nm_r, nm_nxt;
  logic [AW:0]           rem_r, rem_nxt;
  rau_pkg::out_t         out_r, out_nxt;

  logic [rau_pkg::MAG_W-1:0] mul_a, mul_b;
  logic [AW-1:0]         prod;
  logic [AW:0]           rem_sh;
  logic                  qbit;
  logic                  fneg, ovf;

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // Shared multiplier, operands chosen by step count
  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        mul_a = item_r.m0a;
        mul_b = item_r.m0b;
      end
      2'd1: begin
        mul_a = item_r.m1a;
        mul_b = item_r.m1b;
      end
      default: begin
        mul_a = item_r.m2a;
        mul_b = item_r.m2b;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // One restoring division step
  assign rem_sh = {rem_r[AW-1:0], dvd_r[AW-1]};
  assign qbit   = (rem_sh >= {1'b0, g_r});

  // Sign and range of the reduced fraction
  assign fneg = (nneg_r != item_r.negd) && (nm_r != '0);
  assign ovf  = (dvd_r > HALF - 1'b1) || (fneg ? (nm_r > HALF) : (nm_r > HALF - 1'b1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    item_nxt  = item_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    d_nxt     = d_r;
    num_nxt   = num_r;
    nneg_nxt  = nneg_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    g_nxt     = g_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    nm_nxt    = nm_r;
    out_nxt   = out_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          item_nxt = pop_item;
          cnt_nxt  = '0;
          if (pop_item.done) begin
            out_nxt.res_num  = '0;
            out_nxt.res_den  = '0;
            out_nxt.status   = pop_item.status;
            out_nxt.is_equal = pop_item.is_equal;
            state_nxt        = S_OUT;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // store one cross-product per cycle
        case (cnt_r[1:0])
          2'd0: t0_nxt = prod;
          2'd1: t1_nxt = prod;
          default: d_nxt = prod;
        endcase
        if (cnt_r == rau_pkg::SHF_W'(2)) begin
          state_nxt = S_ADD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ADD: begin
        // sign-magnitude add of the two numerator terms
        if (item_r.neg0 == item_r.neg1) begin
          num_nxt  = t0_r + t1_r;
          nneg_nxt = item_r.neg0;
        end else if (t0_r >= t1_r) begin
          num_nxt  = t0_r - t1_r;
          nneg_nxt = item_r.neg0;
        end else begin
          num_nxt  = t1_r - t0_r;
          nneg_nxt = item_r.neg1;
        end
        gx_nxt    = num_nxt;
        gy_nxt    = d_r;
        cnt_nxt   = '0;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        // binary gcd; cnt counts common factors of two
        if (gx_r == '0) begin
          g_nxt     = gy_r << cnt_r;
          dvd_nxt   = num_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt  = gx_r >> 1;
          gy_nxt  = gy_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_nxt = gx_r - gy_r;
        end else begin
          gy_nxt = gy_r - gx_r;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_nxt = qbit ? (rem_sh - {1'b0, g_r}) : rem_sh;
        dvd_nxt = {dvd_r[AW-2:0], qbit};
        if (cnt_r == rau_pkg::SHF_W'(AW - 1)) begin
          cnt_nxt = '0;
          if (state_r == S_DIVN) begin
            nm_nxt    = dvd_nxt;
            dvd_nxt   = d_r;
            rem_nxt   = '0;
            state_nxt = S_DIVD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        out_nxt.is_equal = 1'b0;
        if (ovf) begin
          out_nxt.res_num = '0;
          out_nxt.res_den = '0;
          out_nxt.status  = rau_pkg::ST_OVF;
        end else begin
          out_nxt.res_num = fneg ? rau_pkg::FLD_W'(AW'(0) - nm_r) : rau_pkg::FLD_W'(nm_r);
          out_nxt.res_den = rau_pkg::DEN_W'(dvd_r);
          out_nxt.status  = rau_pkg::ST_OK;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    d_r    <= d_nxt;
    num_r  <= num_nxt;
    nneg_r <= nneg_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    g_r    <= g_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    nm_r   <= nm_nxt;
    out_r  <= out_nxt;
  end

endmodule

/* design/rational_arith_unit.sv */
// Special cases (equality, zero denominator, divide by zero) skip the arithmetic;
// arithmetic runs 3 multiplies, 1 add, a binary gcd loop and 2 x 66 division steps,
// one request at a time in the back end.
// The gcd loop and the bit-serial divider dominate the time per request; the front
// and a two-entry queue take up to three further requests meanwhile.
// Reset: synchronous active-low rst_n empties the queue and returns the back end to idle.
module rational_arith_unit #(
  parameter int unsigned FIELD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::out_t out_data
);

  logic           push, q_full, pop, q_valid;
  rau_pkg::work_t push_item, pop_item;

  // Classify requests
  rau_front #(.FIELD_WIDTH(FIELD_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .q_full    (q_full),
    .push_item (push_item)
  );

  // Decouple front and back
  rau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  // Compute and reduce
  rau_back #(.FIELD_WIDTH(FIELD_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
